FILE: rtl/bpc_pkg.sv
package bpc_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int NOW_BITS          = 32;
    localparam int HOLD_BITS         = 16;
    localparam int NUM_BUTTONS       = 3;
    localparam int BTN_A             = 0;
    localparam int BTN_B             = 1;
    localparam int BTN_C             = 2;

    localparam int IN_BITS           = 40;
    localparam int OUT_BITS          = 16;
    localparam int APB_ADDR_BITS     = 3;
    localparam int APB_DATA_BITS     = 32;

    localparam logic [HOLD_BITS-1:0] LONG_PRESS_RESET = 16'd800;
    localparam logic [HOLD_BITS-1:0] COMBO_HOLD_RESET = 16'd1000;

    typedef enum logic
    {
        REG_LONG_PRESS_TIME = 1'b0,
        REG_COMBO_HOLD_TIME = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic short_ev;
        logic long_ev;
        logic held;
    } lane_evt_t;

endpackage

FILE: rtl/button_press_classifier.sv
// Classifies polls of three push buttons into short, long and A+C chord events.
// Each poll item on the slave stream produces exactly one result item on the
// master stream in the next cycle, and a new poll is taken every cycle as long
// as the output register is empty or being drained in the same cycle. The
// three button lanes and the chord timer update in the cycle of acceptance,
// so the rate is one item per clock, limited only by the output register.
// Timestamp differences wrap modulo 2^TIME_BITS. Configuration registers sit
// at byte 0 (long press time) and byte 4 (combo hold time) and must only be
// written while no poll is in flight.
module button_press_classifier #(
    parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: level_a, level_b, level_c, now_ms[31:0], zero pad.
    input  logic [bpc_pkg::IN_BITS-1:0]         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: short_a, short_b, short_c, long_a, long_b, long_c,
    // combo_ac, held_a, held_b, held_c, zero pad.
    output logic [bpc_pkg::OUT_BITS-1:0]        m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [bpc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [bpc_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    typedef logic [TIME_BITS-1:0] time_t;

    logic [bpc_pkg::HOLD_BITS-1:0] long_press_reg;
    logic [bpc_pkg::HOLD_BITS-1:0] combo_hold_reg;
    bpc_pkg::reg_index_t           reg_sel;
    logic                          cfg_write;
    logic                          accept;
    logic [bpc_pkg::NUM_BUTTONS-1:0] levels;
    time_t                         now;
    logic                          combo;
    bpc_pkg::lane_evt_t            evt [bpc_pkg::NUM_BUTTONS];

    assign pready    = 1'b1;
    assign reg_sel   = bpc_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= bpc_pkg::LONG_PRESS_RESET;
            combo_hold_reg <= bpc_pkg::COMBO_HOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                bpc_pkg::REG_LONG_PRESS_TIME:
                begin
                    long_press_reg <= pwdata[bpc_pkg::HOLD_BITS-1:0];
                end
                bpc_pkg::REG_COMBO_HOLD_TIME:
                begin
                    combo_hold_reg <= pwdata[bpc_pkg::HOLD_BITS-1:0];
                end
                default:
                begin
                    long_press_reg <= long_press_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            bpc_pkg::REG_LONG_PRESS_TIME:
            begin
                prdata = bpc_pkg::APB_DATA_BITS'(long_press_reg);
            end
            bpc_pkg::REG_COMBO_HOLD_TIME:
            begin
                prdata = bpc_pkg::APB_DATA_BITS'(combo_hold_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign levels   = s_tdata[bpc_pkg::NUM_BUTTONS-1:0];
    assign now      = time_t'(s_tdata[bpc_pkg::NUM_BUTTONS +: bpc_pkg::NOW_BITS]);

    for (genvar k = 0; k < bpc_pkg::NUM_BUTTONS; k++)
    begin : g_lane
        logic force_done;
        assign force_done = combo && ((k == bpc_pkg::BTN_A) || (k == bpc_pkg::BTN_C));

        bpc_lane #(
            .TIME_BITS(TIME_BITS)
        ) u_lane (
            .clk             (clk),
            .rst_n           (rst_n),
            .accept          (accept),
            .down            (levels[k]),
            .now             (now),
            .long_press_time (long_press_reg),
            .force_done      (force_done),
            .evt             (evt[k])
        );
    end

    bpc_merge #(
        .TIME_BITS(TIME_BITS)
    ) u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .level_a         (levels[bpc_pkg::BTN_A]),
        .level_c         (levels[bpc_pkg::BTN_C]),
        .now             (now),
        .combo_hold_time (combo_hold_reg),
        .evt             (evt),
        .combo           (combo),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_data        (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_combo_needs_chord: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[6] || (m_tdata[7] && m_tdata[9])))
        else $error("combo event without A and C held");

    a_short_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((!m_tdata[0] || !m_tdata[7]) && (!m_tdata[1] || !m_tdata[8])
                      && (!m_tdata[2] || !m_tdata[9])))
        else $error("short event on a button still held");

    a_result_follows_poll: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted poll gave no result");
`endif

endmodule

FILE: rtl/bpc_lane.sv
module bpc_lane #(
    parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           down,
    input  logic [TIME_BITS-1:0]           now,
    input  logic [bpc_pkg::HOLD_BITS-1:0]  long_press_time,
    input  logic                           force_done,
    output bpc_pkg::lane_evt_t             evt
);

    typedef logic [TIME_BITS-1:0] time_t;

    logic  pressed_reg;
    logic  pressed_next;
    logic  done_reg;
    logic  done_next;
    time_t start_reg;
    time_t start_next;
    time_t elapsed;
    time_t elapsed_after;
    time_t limit;
    logic  press_edge;
    logic  release_edge;
    logic  done_mid;
    logic  short_ev;
    logic  long_ev;

    assign limit        = time_t'(long_press_time);
    assign press_edge   = down && !pressed_reg;
    assign release_edge = !down && pressed_reg;
    assign elapsed      = now - start_reg;
    assign elapsed_after = press_edge ? '0 : elapsed;

    always_comb
    begin
        pressed_next = pressed_reg;
        done_mid     = done_reg;
        start_next   = start_reg;
        short_ev     = 1'b0;
        if (press_edge)
        begin
            pressed_next = 1'b1;
            done_mid     = 1'b0;
            start_next   = now;
        end
        else if (release_edge)
        begin
            short_ev     = !done_reg && (elapsed < limit);
            pressed_next = 1'b0;
            done_mid     = 1'b0;
        end
        long_ev   = pressed_next && !done_mid && (elapsed_after >= limit);
        done_next = done_mid || long_ev || force_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            done_reg    <= 1'b0;
            start_reg   <= '0;
        end
        else if (accept)
        begin
            pressed_reg <= pressed_next;
            done_reg    <= done_next;
            start_reg   <= start_next;
        end
    end

    assign evt.short_ev = short_ev;
    assign evt.long_ev  = long_ev;
    assign evt.held     = pressed_next;

endmodule

FILE: rtl/bpc_merge.sv
module bpc_merge #(
    parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            level_a,
    input  logic                            level_c,
    input  logic [TIME_BITS-1:0]            now,
    input  logic [bpc_pkg::HOLD_BITS-1:0]   combo_hold_time,
    input  bpc_pkg::lane_evt_t              evt [bpc_pkg::NUM_BUTTONS],
    output logic                            combo,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [bpc_pkg::OUT_BITS-1:0]    out_data
);

    typedef logic [TIME_BITS-1:0] time_t;

    logic                         timing_reg;
    logic                         latched_reg;
    time_t                        start_reg;
    time_t                        start_eff;
    time_t                        elapsed;
    logic                         chord;
    logic                         valid_reg;
    logic [bpc_pkg::OUT_BITS-1:0] data_reg;
    logic [bpc_pkg::OUT_BITS-1:0] data_next;

    assign chord     = level_a && level_c;
    assign start_eff = timing_reg ? start_reg : now;
    assign elapsed   = now - start_eff;
    assign combo     = chord && !latched_reg && (elapsed >= time_t'(combo_hold_time));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg  <= 1'b0;
            latched_reg <= 1'b0;
            start_reg   <= '0;
        end
        else if (accept)
        begin
            if (chord)
            begin
                timing_reg  <= 1'b1;
                latched_reg <= latched_reg || combo;
                start_reg   <= start_eff;
            end
            else
            begin
                timing_reg  <= 1'b0;
                latched_reg <= 1'b0;
                start_reg   <= '0;
            end
        end
    end

    // Result bits from the lowest up: short A..C, long A..C, combo, held A..C.
    always_comb
    begin
        data_next     = '0;
        data_next[0]  = evt[bpc_pkg::BTN_A].short_ev;
        data_next[1]  = evt[bpc_pkg::BTN_B].short_ev;
        data_next[2]  = evt[bpc_pkg::BTN_C].short_ev;
        data_next[3]  = evt[bpc_pkg::BTN_A].long_ev;
        data_next[4]  = evt[bpc_pkg::BTN_B].long_ev;
        data_next[5]  = evt[bpc_pkg::BTN_C].long_ev;
        data_next[6]  = combo;
        data_next[7]  = evt[bpc_pkg::BTN_A].held;
        data_next[8]  = evt[bpc_pkg::BTN_B].held;
        data_next[9]  = evt[bpc_pkg::BTN_C].held;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
